// ===== hdl/set_assoc_cache_lfu_read_macros.svh =====
// assertion macros for the lfu read cache
// each macro samples on clk and is disabled while rst_n is low
`ifndef SET_ASSOC_CACHE_LFU_READ_MACROS_SVH
`define SET_ASSOC_CACHE_LFU_READ_MACROS_SVH

`ifndef SYNTHESIS

// condition holds at every edge
`define SALC_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// trigger at one edge implies the result at the next edge
`define SALC_ASSERT_NEXT(lbl, trig, res, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (res)) \
        else $error(msg);

`else

`define SALC_ASSERT(lbl, cond, msg)
`define SALC_ASSERT_NEXT(lbl, trig, res, msg)

`endif

`endif

// ===== hdl/salc_pkg.sv =====
package salc_pkg;

    // default geometry
    localparam int SET_BITS_DEF    = 4;
    localparam int OFFSET_BITS_DEF = 3;
    localparam int WAYS_DEF        = 4;
    localparam int ADDR_BITS_DEF   = 16;
    localparam int COUNT_BITS_DEF  = 16;

    // fixed port widths
    localparam int CFG_W     = 3;
    localparam int FILL_W    = 64;
    localparam int DATA_W    = 8;
    localparam int WAY_OUT_W = 2;

    localparam logic [CFG_W-1:0] ACTIVE_WAYS_RST = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

    // sequencer to compare unit
    typedef struct packed {
        logic step;
        logic first;
    } scan_ctrl_t;

    // compare unit to sequencer
    typedef struct packed {
        logic done;
        logic match;
    } scan_stat_t;

endpackage

// ===== hdl/salc_store.sv =====
module salc_store #(
    parameter int IDX_W      = 6,
    parameter int TAG_W      = 9,
    parameter int COUNT_BITS = 16,
    parameter int LINE_BITS  = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rd_en,
    input  logic [IDX_W-1:0]      rd_idx,
    input  logic                  wr_count_en,
    input  logic                  wr_fill_en,
    input  logic [IDX_W-1:0]      wr_idx,
    input  logic [COUNT_BITS-1:0] wr_count,
    input  logic [TAG_W-1:0]      wr_tag,
    input  logic [LINE_BITS-1:0]  wr_bytes,
    output logic                  q_valid,
    output logic [COUNT_BITS-1:0] q_count,
    output logic [TAG_W-1:0]      q_tag,
    output logic [LINE_BITS-1:0]  q_bytes
);
    localparam int DEPTH = 1 << IDX_W;

    logic [COUNT_BITS-1:0] count_mem_reg [DEPTH];
    logic [TAG_W-1:0]      tag_mem_reg   [DEPTH];
    logic [LINE_BITS-1:0]  line_mem_reg  [DEPTH];
    logic [DEPTH-1:0]      valid_reg;

    logic [COUNT_BITS-1:0] rd_count_reg;
    logic [TAG_W-1:0]      rd_tag_reg;
    logic [LINE_BITS-1:0]  rd_line_reg;
    logic                  rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_count_en)
        begin
            count_mem_reg[wr_idx] <= wr_count;
        end
        if (wr_fill_en)
        begin
            tag_mem_reg[wr_idx]  <= wr_tag;
            line_mem_reg[wr_idx] <= wr_bytes;
        end
        if (rd_en)
        begin
            rd_count_reg <= count_mem_reg[rd_idx];
            rd_tag_reg   <= tag_mem_reg[rd_idx];
            rd_line_reg  <= line_mem_reg[rd_idx];
        end
    end

    // valid bits in flops so reset clears every entry at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_fill_en)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_idx];
            end
        end
    end

    // an entry never filled reads as count zero
    assign q_valid = rd_valid_reg;
    assign q_count = rd_valid_reg ? rd_count_reg : '0;
    assign q_tag   = rd_tag_reg;
    assign q_bytes = rd_line_reg;

endmodule

// ===== hdl/salc_way_cmp.sv =====
module salc_way_cmp #(
    parameter int TAG_W      = 9,
    parameter int COUNT_BITS = 16,
    parameter int WAY_W      = 2
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  salc_pkg::scan_ctrl_t   ctrl,
    input  logic [WAY_W-1:0]       way,
    input  logic [WAY_W-1:0]       last_way,
    input  logic [TAG_W-1:0]       tag,
    input  logic                   q_valid,
    input  logic [COUNT_BITS-1:0]  q_count,
    input  logic [TAG_W-1:0]       q_tag,
    output salc_pkg::scan_stat_t   stat,
    output logic [WAY_W-1:0]       victim,
    output logic [COUNT_BITS-1:0]  count_inc
);
    import salc_pkg::*;

    logic [COUNT_BITS-1:0] min_reg;
    logic [COUNT_BITS-1:0] min_next;
    logic [WAY_W-1:0]      victim_reg;
    logic                  take;

    // shared unit: one tag compare and one count compare per way
    always_comb
    begin
        take       = ctrl.first || (q_count < min_reg);
        victim     = take ? way : victim_reg;
        min_next   = take ? q_count : min_reg;
        stat.match = q_valid && (q_tag == tag);
        stat.done  = stat.match || (way == last_way);
        count_inc  = (&q_count) ? q_count : q_count + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg    <= '0;
            victim_reg <= '0;
        end
        else if (ctrl.step)
        begin
            min_reg    <= min_next;
            victim_reg <= victim;
        end
    end

endmodule

// ===== hdl/salc_seq.sv =====
module salc_seq #(
    parameter int WAYS  = 4,
    parameter int WAY_W = 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [salc_pkg::CFG_W-1:0] active_ways,
    input  salc_pkg::scan_stat_t       stat,
    input  logic                       out_busy,
    output logic                       in_ready,
    output logic                       load,
    output logic                       finish,
    output logic                       commit,
    output logic                       rd_en,
    output logic [WAY_W-1:0]           rd_way,
    output logic [WAY_W-1:0]           way,
    output logic [WAY_W-1:0]           last_way,
    output salc_pkg::scan_ctrl_t       ctrl
);
    import salc_pkg::*;

    state_t           state_reg;
    state_t           state_next;
    logic [WAY_W-1:0] way_reg;
    logic [WAY_W-1:0] way_next;
    logic [WAY_W-1:0] last_way_reg;
    logic [WAY_W-1:0] last_way_next;

    // clamp the way count into 1..WAYS
    always_comb
    begin
        priority if (active_ways == '0)
        begin
            last_way_next = '0;
        end
        else if (32'(active_ways) >= WAYS)
        begin
            last_way_next = WAY_W'(WAYS - 1);
        end
        else
        begin
            last_way_next = WAY_W'(active_ways - 1'b1);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (!out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        ctrl.step  = 1'b0;
        ctrl.first = 1'b0;
        commit     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_SCAN:
            begin
                ctrl.step  = 1'b1;
                ctrl.first = (way_reg == '0);
            end
            ST_UPDATE:
            begin
                commit = !out_busy;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        load     = in_ready && in_valid;
        finish   = ctrl.step && stat.done;
        // way 0 is read on accept, then one way ahead of the compare
        rd_en    = load || (ctrl.step && !stat.done);
        rd_way   = load ? '0 : way_reg + 1'b1;
        way_next = load ? '0 : (rd_en ? way_reg + 1'b1 : way_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            way_reg      <= '0;
            last_way_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            way_reg   <= way_next;
            if (load)
            begin
                last_way_reg <= last_way_next;
            end
        end
    end

    assign way      = way_reg;
    assign last_way = last_way_reg;

endmodule

// ===== hdl/set_assoc_cache_lfu_read.sv =====
// channel | beat signals              | payload
// --------+---------------------------+------------------------------
// in      | in_valid / in_ready       | address, fill_line
// out     | out_valid / out_ready     | read_data, hit, way_used
// cfg     | cfg_valid / cfg_ready     | active_ways
//
// from accept to result an item reads way 0 in the accept cycle, steps through
// the active ways (1..WAYS) one at a time through the shared tag and count
// compare, then writes back the set entry
// a hit stops the scan at the matching way, so hits finish sooner
// in_ready is high only while idle; cfg_ready is always high
// the result waits in the output register; a stalled output holds the block
// in the write back cycle until the register frees up
// reset clears every line's valid bit at once, no clearing pass
`include "set_assoc_cache_lfu_read_macros.svh"

module set_assoc_cache_lfu_read #(
    parameter int SET_BITS    = salc_pkg::SET_BITS_DEF,
    parameter int OFFSET_BITS = salc_pkg::OFFSET_BITS_DEF,
    parameter int WAYS        = salc_pkg::WAYS_DEF,
    parameter int ADDR_BITS   = salc_pkg::ADDR_BITS_DEF,
    parameter int COUNT_BITS  = salc_pkg::COUNT_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [salc_pkg::CFG_W-1:0]     active_ways,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ADDR_BITS-1:0]           address,
    input  logic [salc_pkg::FILL_W-1:0]    fill_line,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [salc_pkg::DATA_W-1:0]    read_data,
    output logic                           hit,
    output logic [salc_pkg::WAY_OUT_W-1:0] way_used
);
    import salc_pkg::*;

    localparam int NUM_SETS   = 1 << SET_BITS;
    localparam int LINE_BYTES = 1 << OFFSET_BITS;
    localparam int LINE_BITS  = 8 * LINE_BYTES;
    localparam int TAG_BITS   = ADDR_BITS - SET_BITS - OFFSET_BITS;
    localparam int TAG_W      = (TAG_BITS > 0) ? TAG_BITS : 1;
    localparam int SET_W      = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int OFF_W      = (OFFSET_BITS > 0) ? OFFSET_BITS : 1;
    localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int IDX_W      = SET_W + WAY_W;

    // configuration
    logic [CFG_W-1:0] active_ways_reg;

    // address fields of the item in flight
    logic [SET_W-1:0]     in_set;
    logic [TAG_W-1:0]     in_tag;
    logic [OFF_W-1:0]     in_off;
    logic [SET_W-1:0]     set_reg;
    logic [TAG_W-1:0]     tag_reg;
    logic [OFF_W-1:0]     off_reg;
    logic [LINE_BITS-1:0] line_reg;

    // sequencer and compare unit
    scan_ctrl_t           ctrl;
    scan_stat_t           stat;
    logic                 load;
    logic                 finish;
    logic                 commit;
    logic                 rd_en;
    logic [WAY_W-1:0]     rd_way;
    logic [WAY_W-1:0]     cmp_way;
    logic [WAY_W-1:0]     last_way;
    logic [WAY_W-1:0]     victim;
    logic [COUNT_BITS-1:0] count_inc;
    logic                 out_busy;

    // store
    logic [IDX_W-1:0]      rd_idx;
    logic [IDX_W-1:0]      wr_idx;
    logic                  wr_count_en;
    logic                  wr_fill_en;
    logic                  q_valid;
    logic [COUNT_BITS-1:0] q_count;
    logic [TAG_W-1:0]      q_tag;
    logic [LINE_BITS-1:0]  q_bytes;

    // result of the scan, held through write back
    logic                  res_hit_reg;
    logic [WAY_W-1:0]      res_way_reg;
    logic [DATA_W-1:0]     res_byte_reg;
    logic [COUNT_BITS-1:0] res_count_reg;
    logic [LINE_BITS-1:0]  hit_shift;
    logic [LINE_BITS-1:0]  fill_shift;

    // output register
    logic                 out_valid_reg;
    logic [DATA_W-1:0]    read_data_reg;
    logic                 hit_reg;
    logic [WAY_OUT_W-1:0] way_used_reg;

    // config port never stalls; the user must write it only while idle, the block does not enforce this
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_ways_reg <= ACTIVE_WAYS_RST;
        end
        else if (cfg_valid)
        begin
            active_ways_reg <= active_ways;
        end
    end

    // offset, set, tag from low to high address bits
    assign in_off = OFF_W'(address & ADDR_BITS'(LINE_BYTES - 1));
    assign in_set = SET_W'((address >> OFFSET_BITS) & ADDR_BITS'(NUM_SETS - 1));
    assign in_tag = TAG_W'(address >> (OFFSET_BITS + SET_BITS));

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            set_reg  <= in_set;
            tag_reg  <= in_tag;
            off_reg  <= in_off;
            // bytes past the line length are dropped
            line_reg <= fill_line[LINE_BITS-1:0];
        end
    end

    salc_seq #(
        .WAYS  (WAYS),
        .WAY_W (WAY_W)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .active_ways (active_ways_reg),
        .stat        (stat),
        .out_busy    (out_busy),
        .in_ready    (in_ready),
        .load        (load),
        .finish      (finish),
        .commit      (commit),
        .rd_en       (rd_en),
        .rd_way      (rd_way),
        .way         (cmp_way),
        .last_way    (last_way),
        .ctrl        (ctrl)
    );

    // way 0 is read in the accept cycle, using the incoming set
    assign rd_idx = {(load ? in_set : set_reg), rd_way};
    assign wr_idx = {set_reg, res_way_reg};

    // a hit bumps the count only; a miss refills the whole entry
    assign wr_count_en = commit;
    assign wr_fill_en  = commit && !res_hit_reg;

    salc_store #(
        .IDX_W      (IDX_W),
        .TAG_W      (TAG_W),
        .COUNT_BITS (COUNT_BITS),
        .LINE_BITS  (LINE_BITS)
    ) u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .rd_en       (rd_en),
        .rd_idx      (rd_idx),
        .wr_count_en (wr_count_en),
        .wr_fill_en  (wr_fill_en),
        .wr_idx      (wr_idx),
        .wr_count    (res_count_reg),
        .wr_tag      (tag_reg),
        .wr_bytes    (line_reg),
        .q_valid     (q_valid),
        .q_count     (q_count),
        .q_tag       (q_tag),
        .q_bytes     (q_bytes)
    );

    salc_way_cmp #(
        .TAG_W      (TAG_W),
        .COUNT_BITS (COUNT_BITS),
        .WAY_W      (WAY_W)
    ) u_way_cmp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .way       (cmp_way),
        .last_way  (last_way),
        .tag       (tag_reg),
        .q_valid   (q_valid),
        .q_count   (q_count),
        .q_tag     (q_tag),
        .stat      (stat),
        .victim    (victim),
        .count_inc (count_inc)
    );

    // byte select from the cached line on a hit, from the fill line on a miss
    assign hit_shift  = q_bytes >> {off_reg, 3'b000};
    assign fill_shift = line_reg >> {off_reg, 3'b000};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_hit_reg <= 1'b0;
            res_way_reg <= '0;
        end
        else if (finish)
        begin
            res_hit_reg <= stat.match;
            res_way_reg <= stat.match ? cmp_way : victim;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            res_byte_reg  <= stat.match ? hit_shift[DATA_W-1:0] : fill_shift[DATA_W-1:0];
            // fresh line starts at count one
            res_count_reg <= stat.match ? count_inc : COUNT_BITS'(1);
        end
    end

    // output register frees the cache from the consumer
    assign out_busy = out_valid_reg && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            read_data_reg <= res_byte_reg;
            hit_reg       <= res_hit_reg;
            way_used_reg  <= WAY_OUT_W'(res_way_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign hit       = hit_reg;
    assign way_used  = way_used_reg;

    // an accepted item keeps the input closed while the scan runs
    `SALC_ASSERT_NEXT(a_busy_after_accept, load, !in_ready, "input open right after accept")
    // write back always produces a beat on the next cycle
    `SALC_ASSERT_NEXT(a_commit_shows, commit, out_valid, "write back without result beat")
    // refill only ever lands in an active way
    `SALC_ASSERT(a_victim_active, !wr_fill_en || (res_way_reg <= last_way), "victim out of range")
    // store is never read and written in the same cycle
    `SALC_ASSERT(a_no_rw_overlap, !(rd_en && wr_count_en), "store read during write back")

endmodule

// ===== bench/tb_set_assoc_cache_lfu_read.sv =====
`timescale 1ns / 1ps

module tb_set_assoc_cache_lfu_read;
    import salc_pkg::*;

    // geometry of the block under test, default parameters
    localparam int ADDR_W = ADDR_BITS_DEF;
    localparam int OFS_W  = OFFSET_BITS_DEF;
    localparam int SET_W  = SET_BITS_DEF;
    localparam int TAG_W  = ADDR_W - SET_W - OFS_W;
    localparam int NWAYS  = WAYS_DEF;
    localparam int NSETS  = 1 << SET_W;
    localparam int CNT_W  = COUNT_BITS_DEF;

    // idle cycles with no beat on any channel before the run is declared hung
    localparam int WATCHDOG_LIMIT = 1000;
    // back to back reads of one line with a single active way, all but the first hit
    localparam int SOAK_HITS = 10;
    localparam int RAND_PHASES = 8;
    localparam int RAND_ITEMS = 102;

    // one read request as the sender presents it
    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [FILL_W-1:0] line;
    } read_req_t;

    // one read result as the block should return it
    typedef struct {
        logic [DATA_W-1:0]    data;
        logic                 hit;
        logic [WAY_OUT_W-1:0] way;
    } read_beat_t;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 cfg_valid   = 1'b0;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     active_ways = '0;
    logic                 in_valid    = 1'b0;
    logic                 in_ready;
    logic [ADDR_W-1:0]    address     = '0;
    logic [FILL_W-1:0]    fill_line   = '0;
    logic                 out_valid;
    logic                 out_ready   = 1'b0;
    logic [DATA_W-1:0]    read_data;
    logic                 hit;
    logic [WAY_OUT_W-1:0] way_used;

    set_assoc_cache_lfu_read dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .active_ways (active_ways),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .address     (address),
        .fill_line   (fill_line),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_data   (read_data),
        .hit         (hit),
        .way_used    (way_used)
    );

    always #2 clk = ~clk;

    // shadow copy of the cache contents, starts as after reset
    logic [CFG_W-1:0]  cache_ways = ACTIVE_WAYS_RST;
    logic              cache_valid [NSETS][NWAYS] = '{default: '0};
    logic [CNT_W-1:0]  cache_count [NSETS][NWAYS] = '{default: '0};
    logic [TAG_W-1:0]  cache_tag   [NSETS][NWAYS] = '{default: '0};
    logic [FILL_W-1:0] cache_line  [NSETS][NWAYS] = '{default: '0};

    read_req_t  pending_reads[$];   // requests not yet handed to the driver
    read_beat_t expected_reads[$];  // predicted results, oldest first

    int  reads_queued  = 0;   // requests pushed by the stimulus
    int  reads_checked = 0;   // result beats seen by the monitor
    int  cfg_beats     = 0;
    int  error_count   = 0;
    int  idle_cycles   = 0;
    int  in_gap        = 0;
    int  out_stall     = 0;
    logic in_beat      = 1'b0;  // the request on the bus was taken at the last rising edge
    logic burst_mode   = 1'b0;  // no idling on either side while set

    // lookup with lfu replacement, updates the shadow copy and returns the result
    function automatic read_beat_t lfu_lookup(input logic [ADDR_W-1:0] addr,
                                              input logic [FILL_W-1:0] line);
        logic [OFS_W-1:0] ofs;
        logic [SET_W-1:0] st;
        logic [TAG_W-1:0] tg;
        logic [CNT_W-1:0] min_cnt;
        int               n;
        int               victim;
        read_beat_t       r;
        ofs = addr[OFS_W-1:0];
        st  = addr[OFS_W +: SET_W];
        tg  = addr[ADDR_W-1 -: TAG_W];
        // zero ways acts as one, anything above the way count as all of them
        if (cache_ways == 0)
            n = 1;
        else if (cache_ways > NWAYS)
            n = NWAYS;
        else
            n = cache_ways;
        victim  = 0;
        min_cnt = cache_count[st][0];
        for (int w = 0; w < n; w++)
        begin
            if (cache_valid[st][w] && cache_tag[st][w] == tg)
            begin
                // saturating use count, fill line ignored on a hit
                if (cache_count[st][w] != '1)
                    cache_count[st][w] = cache_count[st][w] + 1'b1;
                r.data = DATA_W'(cache_line[st][w] >> (8 * ofs));
                r.hit  = 1'b1;
                r.way  = WAY_OUT_W'(w);
                return r;
            end
            // strict compare keeps the lowest way on ties
            if (cache_count[st][w] < min_cnt)
            begin
                min_cnt = cache_count[st][w];
                victim  = w;
            end
        end
        cache_valid[st][victim] = 1'b1;
        cache_count[st][victim] = 1;
        cache_tag[st][victim]   = tg;
        cache_line[st][victim]  = line;
        r.data = DATA_W'(line >> (8 * ofs));
        r.hit  = 1'b0;
        r.way  = WAY_OUT_W'(victim);
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input int tg, input int st, input int ofs);
        return ADDR_W'((tg << (SET_W + OFS_W)) | (st << OFS_W) | ofs);
    endfunction

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (burst_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic note_fail(input string msg);
        if (error_count < 10)
            $display("%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // called at a rising edge only, so the driver never races the push
    task automatic queue_read(input logic [ADDR_W-1:0] a, input logic [FILL_W-1:0] l);
        read_req_t q;
        q.addr = a;
        q.line = l;
        pending_reads.push_back(q);
        reads_queued++;
    endtask

    // wait until every result is back, then give the block time to settle
    task automatic drain();
        while (reads_checked < reads_queued)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // register write, only issued while the block is idle
    task automatic set_ways(input logic [CFG_W-1:0] v);
        int seen;
        @(negedge clk);
        seen = cfg_beats;
        active_ways <= v;
        cfg_valid   <= 1'b1;
        do
            @(negedge clk);
        while (cfg_beats == seen);
        cfg_valid <= 1'b0;
    endtask

    // request driver: holds a beat until taken, then an optional gap
    always @(negedge clk)
    begin : drive_req
        logic      nv;
        read_req_t q;
        if (rst_n)
        begin
            nv = in_valid;
            if (in_valid && in_beat)
                nv = 1'b0;
            if (!nv)
            begin
                if (in_gap > 0)
                    in_gap <= in_gap - 1;
                else if (pending_reads.size() > 0)
                begin
                    q = pending_reads.pop_front();
                    address   <= q.addr;
                    fill_line <= q.line;
                    nv = 1'b1;
                    in_gap <= pick_gap();
                end
            end
            in_valid <= nv;
        end
    end

    // result side back pressure
    always @(negedge clk)
    begin : drive_ready
        if (rst_n)
        begin
            if (out_stall > 0 && !burst_mode)
            begin
                out_ready <= 1'b0;
                out_stall <= out_stall - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!burst_mode && $urandom_range(0, 99) < 25)
                    out_stall <= pick_gap() + 1;
                else
                    out_stall <= 0;
            end
        end
    end

    // monitor: config beats, result checks, request predictions, watchdog
    always @(posedge clk)
    begin : watch
        read_beat_t e;
        logic       any_beat;
        if (rst_n)
        begin
            any_beat = 1'b0;
            in_beat <= in_valid && in_ready;
            if (cfg_valid && cfg_ready)
            begin
                cache_ways = active_ways;
                cfg_beats <= cfg_beats + 1;
                any_beat = 1'b1;
            end
            if (out_valid && out_ready)
            begin
                any_beat = 1'b1;
                reads_checked <= reads_checked + 1;
                if (expected_reads.size() == 0)
                    note_fail($sformatf("result with nothing pending: data %h hit %b way %0d",
                                        read_data, hit, way_used));
                else
                begin
                    e = expected_reads.pop_front();
                    if (read_data !== e.data || hit !== e.hit || way_used !== e.way)
                        note_fail($sformatf(
                            "read mismatch: expected data %h hit %b way %0d, got %h %b %0d",
                            e.data, e.hit, e.way, read_data, hit, way_used));
                end
            end
            // predict after the check, the new request queues behind older results
            if (in_valid && in_ready)
            begin
                any_beat = 1'b1;
                expected_reads.push_back(lfu_lookup(address, fill_line));
            end
            if (any_beat)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        logic [CFG_W-1:0] cfg_seq [RAND_PHASES];
        logic [TAG_W-1:0] tag_pool [6];
        logic [SET_W-1:0] set_pool [4];
        int               t;
        int               i;
        int               p;

        cfg_seq = '{3'd0, 3'd3, 3'd7, 3'd2, 3'd5, 3'd4, 3'd6, 3'd1};

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // directed part, four ways as after reset
        @(posedge clk);
        // tag zero against invalid lines of all zero tag must still miss
        queue_read(16'h0000, 64'h0123_4567_89AB_CDEF);
        // hit on the top byte, the fill line is ignored
        queue_read(16'h0007, 64'h0);
        // all ones address and line, then a hit on its low byte
        queue_read(16'hFFFF, '1);
        queue_read(16'hFFF8, 64'h0);
        // fill all four ways of set one
        for (t = 1; t <= 4; t++)
            queue_read(addr_of(t, 1, t), {$urandom, $urandom});
        // bump counts so the victim is not simply way zero, the first way scanned
        queue_read(addr_of(3, 1, 0), 64'h0);
        queue_read(addr_of(3, 1, 5), 64'h0);
        queue_read(addr_of(1, 1, 2), 64'h0);
        // counts 2 1 3 1: ties go to the lower way
        queue_read(addr_of(5, 1, 7), {$urandom, $urandom});
        queue_read(addr_of(2, 1, 4), {$urandom, $urandom});
        queue_read(addr_of(4, 1, 6), {$urandom, $urandom});
        // alternating bit patterns on address and line
        queue_read(16'hAAAA, {2{32'hAAAA_AAAA}});
        queue_read(16'h5555, {2{32'h5555_5555}});
        queue_read(16'hAAAB, {2{32'h5555_5555}});
        drain();

        // heat up one line with a single active way
        set_ways(3'd1);
        burst_mode <= 1'b1;
        @(posedge clk);
        for (i = 0; i < SOAK_HITS; i++)
            queue_read(addr_of(20, 2, $urandom_range(0, 7)), {$urandom, $urandom});
        drain();

        // reopen way one: the hot line stays put, misses keep landing in way one
        set_ways(3'd2);
        @(posedge clk);
        queue_read(addr_of(21, 2, 0), {$urandom, $urandom});
        queue_read(addr_of(22, 2, 3), {$urandom, $urandom});
        queue_read(addr_of(20, 2, 5), {$urandom, $urandom});
        queue_read(addr_of(23, 2, 7), {$urandom, $urandom});
        queue_read(addr_of(20, 2, 1), {$urandom, $urandom});
        drain();

        // random phases, each with its own way count and a small working set
        for (p = 0; p < RAND_PHASES; p++)
        begin
            set_ways(cfg_seq[p]);
            burst_mode <= (p % 3 == 2);
            for (i = 0; i < 6; i++)
                tag_pool[i] = TAG_W'($urandom);
            for (i = 0; i < 4; i++)
                set_pool[i] = SET_W'($urandom);
            @(posedge clk);
            for (i = 0; i < RAND_ITEMS; i++)
            begin
                // mostly a small working set so hits and evictions mix, rest anywhere
                if ($urandom_range(0, 99) < 75)
                    queue_read(addr_of(tag_pool[$urandom_range(0, 5)],
                                       set_pool[$urandom_range(0, 3)],
                                       $urandom_range(0, 7)),
                               {$urandom, $urandom});
                else
                    queue_read(ADDR_W'($urandom), {$urandom, $urandom});
            end
            // sender holds off here until every result is back
            drain();
        end

        if (error_count == 0 && expected_reads.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/salc_pkg.sv
hdl/salc_store.sv
hdl/salc_way_cmp.sv
hdl/salc_seq.sv
hdl/set_assoc_cache_lfu_read.sv
bench/tb_set_assoc_cache_lfu_read.sv
